// ===== design/ppc_pkg.sv =====
// shared types and constants for the perspective projection and cull block
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    // fixed field widths
    localparam int AXIS_W    = 16;
    localparam int LANES     = 3;
    localparam int FOCAL_W   = 16;
    localparam int CENTER_W  = 15;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd6;

    typedef logic [3*AXIS_W-1:0] axis_vec_t;

    // reset values of the configuration registers
    localparam logic [AXIS_W-1:0]   AXIS_ONE     = 16'h4000;
    localparam logic [AXIS_W-1:0]   AXIS_ZERO    = 16'h0000;
    localparam axis_vec_t           VIEW_RESET   = {AXIS_ONE, AXIS_ZERO, AXIS_ZERO};
    localparam axis_vec_t           RIGHT_RESET  = {AXIS_ZERO, AXIS_ZERO, AXIS_ONE};
    localparam axis_vec_t           UP_RESET     = {AXIS_ZERO, AXIS_ONE, AXIS_ZERO};
    localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 16'd400;
    localparam logic [CENTER_W-1:0] CX_RESET     = 15'd600;
    localparam logic [CENTER_W-1:0] CY_RESET     = 15'd300;

    // zero depth gives an offset of two to this power
    localparam int ZERO_DEPTH_LOG = 40;
    localparam logic [OUT_W-1:0] DIM_MAX = 16'hFFFF;

    // flags that ride along with the divider lanes
    typedef struct packed {
        logic sx;
        logic nzx;
        logic sy;
        logic nzy;
        logic rpos;
        logic zero;
        logic behind;
    } div_side_t;

endpackage

`default_nettype wire

// ===== design/perspective_project_cull_top.sv =====
// top level: projection of one sphere per transfer onto the window, with culling
`timescale 1ns / 1ps
`default_nettype none

// Takes one transfer per clock unless the result side stalls and returns one
// result per input transfer, in order. The pipeline holds nine arithmetic
// stages, one stage per quotient bit of the pipelined divider (the numerator
// width of focal*projection), and four stages of rounding, offsetting, window
// position, and culling with saturation. A stall on the result side freezes
// the whole pipeline; s_ready follows m_ready while a result is held.
// Configuration writes take effect at once and must be made with the pipeline
// empty.

module perspective_project_cull_top #(
    parameter int COORD_BITS     = 21,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [3*COORD_BITS-1:0]            cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_BITS-1:0]       s_point_x,
    input  logic signed [COORD_BITS-1:0]       s_point_y,
    input  logic signed [COORD_BITS-1:0]       s_point_z,
    input  logic [COORD_BITS-2:0]              s_bound_radius,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ppc_pkg::OUT_W-1:0]   m_window_x,
    output logic signed [ppc_pkg::OUT_W-1:0]   m_window_y,
    output logic [ppc_pkg::OUT_W-1:0]          m_screen_radius,
    output logic                               m_visible
);
    import ppc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = AXIS_FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int PDW  = DW + AXIS_W;
    localparam int UW   = PDW + 2;
    localparam int UDW  = UW + AXIS_W;
    localparam int SHW  = UDW - F;
    localparam int DSW  = DW + F;
    localparam int PW   = ((SHW > DSW) ? SHW : DSW) + 1;
    localparam int PPW  = PW + AXIS_W;
    localparam int NPW  = PPW + 2;
    localparam int NFW  = NPW - F;
    localparam int NSW  = NFW + FOCAL_W + 1;
    localparam int RW   = C - 1;
    localparam int RSW  = RW + F;
    localparam int RZW  = RSW + FOCAL_W;
    localparam int MW   = NSW;
    localparam int QW   = MW + 1;
    localparam int WW   = MW + 3;

    // configuration registers
    logic [3*C-1:0]      cam_reg;
    axis_vec_t           dir_reg;
    axis_vec_t           right_reg;
    axis_vec_t           up_reg;
    logic [FOCAL_W-1:0]  focal_reg;
    logic [CENTER_W-1:0] cx_reg;
    logic [CENTER_W-1:0] cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg   <= '0;
            dir_reg   <= VIEW_RESET;
            right_reg <= RIGHT_RESET;
            up_reg    <= UP_RESET;
            focal_reg <= FOCAL_RESET;
            cx_reg    <= CX_RESET;
            cy_reg    <= CY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CAMERA:   cam_reg   <= cfg_data;
                REG_VIEW:     dir_reg   <= cfg_data[3*AXIS_W-1:0];
                REG_RIGHT:    right_reg <= cfg_data[3*AXIS_W-1:0];
                REG_UP:       up_reg    <= cfg_data[3*AXIS_W-1:0];
                REG_FOCAL:    focal_reg <= cfg_data[FOCAL_W-1:0];
                REG_CENTER_X: cx_reg    <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: cy_reg    <= cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // unpacked axes and camera
    logic signed [AXIS_W-1:0] dir_a [LANES];
    logic signed [AXIS_W-1:0] rt_a  [LANES];
    logic signed [AXIS_W-1:0] up_a  [LANES];
    logic signed [C-1:0]      cam_a [LANES];
    logic signed [C-1:0]      pt_a  [LANES];
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            dir_a[i] = $signed(dir_reg[i*AXIS_W +: AXIS_W]);
            rt_a[i]  = $signed(right_reg[i*AXIS_W +: AXIS_W]);
            up_a[i]  = $signed(up_reg[i*AXIS_W +: AXIS_W]);
            cam_a[i] = $signed(cam_reg[i*C +: C]);
        end
        pt_a[0] = s_point_x;
        pt_a[1] = s_point_y;
        pt_a[2] = s_point_z;
    end

    // pipeline advance: everything moves unless a result is held
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic           dv_out;

    // stage registers
    logic signed [DW-1:0]  d1_reg  [LANES];
    logic [RW-1:0]         r1_reg;
    logic signed [PDW-1:0] pd2_reg [LANES];
    logic signed [DW-1:0]  d2_reg  [LANES];
    logic [RW-1:0]         r2_reg;
    logic signed [UW-1:0]  u3_reg;
    logic signed [DW-1:0]  d3_reg  [LANES];
    logic [RW-1:0]         r3_reg;
    logic signed [UDW-1:0] ud4_reg [LANES];
    logic signed [DW-1:0]  d4_reg  [LANES];
    logic signed [UW-1:0]  u4_reg;
    logic [RW-1:0]         r4_reg;
    logic                  beh4_reg;
    logic signed [PW-1:0]  pp5_reg [LANES];
    logic signed [UW-1:0]  u5_reg;
    logic [RW-1:0]         r5_reg;
    logic                  beh5_reg;
    logic signed [PPW-1:0] pr6_reg [LANES];
    logic signed [PPW-1:0] pu6_reg [LANES];
    logic signed [UW-1:0]  u6_reg;
    logic [RW-1:0]         r6_reg;
    logic                  beh6_reg;
    logic signed [NFW-1:0] nx7_reg;
    logic signed [NFW-1:0] ny7_reg;
    logic signed [UW-1:0]  u7_reg;
    logic [RW-1:0]         r7_reg;
    logic                  beh7_reg;
    logic signed [NSW-1:0] nz8_reg [2];
    logic [RZW-1:0]        rz8_reg;
    logic [UW-1:0]         au8_reg;
    logic                  zero8_reg;
    logic                  rpos8_reg;
    logic                  beh8_reg;
    logic [MW-1:0]         mag9_reg [LANES];
    logic [UW-1:0]         au9_reg;
    div_side_t             side9_reg;

    // stage 1 to 9 next values
    logic signed [DW-1:0]  d1_next  [LANES];
    logic signed [PDW-1:0] pd2_next [LANES];
    logic signed [UW-1:0]  u3_next;
    logic signed [UDW-1:0] ud4_next [LANES];
    logic                  beh4_next;
    logic signed [PW-1:0]  pp5_next [LANES];
    logic signed [PPW-1:0] pr6_next [LANES];
    logic signed [PPW-1:0] pu6_next [LANES];
    logic signed [NFW-1:0] nx7_next;
    logic signed [NFW-1:0] ny7_next;
    logic signed [NSW-1:0] nz8_next [2];
    logic [RZW-1:0]        rz8_next;
    logic [UW-1:0]         au8_next;
    logic [MW-1:0]         mag9_next [LANES];
    div_side_t             side9_next;

    // depth, perpendicular part and the two projections
    always_comb begin
        logic signed [UW-1:0]  rs3;
        logic signed [SHW-1:0] uds;
        logic signed [PW-1:0]  dsh;
        logic signed [NPW-1:0] sx7;
        logic signed [NPW-1:0] sy7;
        logic signed [NSW-1:0] z0;
        for (int i = 0; i < LANES; i++) begin
            d1_next[i]  = DW'(pt_a[i]) - DW'(cam_a[i]);
            pd2_next[i] = PDW'(d1_reg[i]) * PDW'(dir_a[i]);
            ud4_next[i] = UDW'(u3_reg) * UDW'(dir_a[i]);
            uds         = SHW'(ud4_reg[i] >>> F);
            dsh         = PW'(d4_reg[i]) <<< F;
            pp5_next[i] = dsh - PW'(uds);
            pr6_next[i] = PPW'(pp5_reg[i]) * PPW'(rt_a[i]);
            pu6_next[i] = PPW'(pp5_reg[i]) * PPW'(up_a[i]);
        end
        u3_next   = UW'(pd2_reg[0]) + UW'(pd2_reg[1]) + UW'(pd2_reg[2]);
        rs3       = UW'({r3_reg, {F{1'b0}}});
        beh4_next = u3_reg < rs3;
        sx7       = NPW'(pr6_reg[0]) + NPW'(pr6_reg[1]) + NPW'(pr6_reg[2]);
        sy7       = NPW'(pu6_reg[0]) + NPW'(pu6_reg[1]) + NPW'(pu6_reg[2]);
        nx7_next  = NFW'(sx7 >>> F);
        ny7_next  = NFW'(sy7 >>> F);
        z0          = NSW'($signed({1'b0, focal_reg}));
        nz8_next[0] = NSW'(nx7_reg) * z0;
        nz8_next[1] = NSW'(ny7_reg) * z0;
        rz8_next    = RZW'({r7_reg, {F{1'b0}}}) * RZW'(focal_reg);
        au8_next    = u7_reg[UW-1] ? UW'(-u7_reg) : UW'(u7_reg);
        for (int j = 0; j < 2; j++) begin
            mag9_next[j] = nz8_reg[j][NSW-1] ? MW'(-nz8_reg[j]) : MW'(nz8_reg[j]);
        end
        mag9_next[2]      = MW'(rz8_reg);
        side9_next.sx     = nz8_reg[0][NSW-1];
        side9_next.nzx    = nz8_reg[0] != '0;
        side9_next.sy     = nz8_reg[1][NSW-1];
        side9_next.nzy    = nz8_reg[1] != '0;
        side9_next.rpos   = rpos8_reg;
        side9_next.zero   = zero8_reg;
        side9_next.behind = beh8_reg;
    end

    // front stage data
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg    <= s_bound_radius;
            r2_reg    <= r1_reg;
            r3_reg    <= r2_reg;
            r4_reg    <= r3_reg;
            r5_reg    <= r4_reg;
            r6_reg    <= r5_reg;
            r7_reg    <= r6_reg;
            u3_reg    <= u3_next;
            u4_reg    <= u3_reg;
            u5_reg    <= u4_reg;
            u6_reg    <= u5_reg;
            u7_reg    <= u6_reg;
            beh4_reg  <= beh4_next;
            beh5_reg  <= beh4_reg;
            beh6_reg  <= beh5_reg;
            beh7_reg  <= beh6_reg;
            beh8_reg  <= beh7_reg;
            nx7_reg   <= nx7_next;
            ny7_reg   <= ny7_next;
            rz8_reg   <= rz8_next;
            au8_reg   <= au8_next;
            zero8_reg <= u7_reg == '0;
            rpos8_reg <= r7_reg != '0;
            au9_reg   <= au8_reg;
            side9_reg <= side9_next;
            for (int i = 0; i < LANES; i++) begin
                d1_reg[i]   <= d1_next[i];
                pd2_reg[i]  <= pd2_next[i];
                d2_reg[i]   <= d1_reg[i];
                d3_reg[i]   <= d2_reg[i];
                d4_reg[i]   <= d3_reg[i];
                ud4_reg[i]  <= ud4_next[i];
                pp5_reg[i]  <= pp5_next[i];
                pr6_reg[i]  <= pr6_next[i];
                pu6_reg[i]  <= pu6_next[i];
                mag9_reg[i] <= mag9_next[i];
            end
            nz8_reg[0] <= nz8_next[0];
            nz8_reg[1] <= nz8_next[1];
        end
    end

    // three divisions by |U|
    logic [MW-1:0] q_div   [LANES];
    logic          rnd_div [LANES];
    div_side_t     side_div;

    ppc_div #(
        .NW (MW),
        .DW (UW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v9_reg),
        .in_num    (mag9_reg),
        .in_den    (au9_reg),
        .in_side   (side9_reg),
        .out_valid (dv_out),
        .out_quot  (q_div),
        .out_round (rnd_div),
        .out_side  (side_div)
    );

    // back stages
    logic [MW-1:0]          qa_reg [LANES];
    div_side_t              sa_reg;
    logic signed [QW-1:0]   ox_reg, oy_reg, dimb_reg;
    logic                   behb_reg;
    logic signed [WW-1:0]   wx_reg, wy_reg, dimc_reg;
    logic                   behc_reg;
    logic signed [OUT_W-1:0] wxo_reg, wyo_reg;
    logic [OUT_W-1:0]       dimo_reg;
    logic                   viso_reg;

    logic signed [QW-1:0]   ox_next, oy_next, dimb_next;
    logic signed [WW-1:0]   wx_next, wy_next;
    logic signed [OUT_W-1:0] wxo_next, wyo_next;
    logic [OUT_W-1:0]       dimo_next;
    logic                   viso_next;

    // signed offsets with the zero depth case, window position, culling, saturation
    always_comb begin
        logic signed [QW-1:0] zofs;
        logic signed [QW-1:0] mx, my;
        logic signed [WW-1:0] sat_lo, sat_hi, dmax;
        logic signed [WW-1:0] lim_x, lim_y;
        logic out_l, out_r, out_t, out_b;
        zofs = QW'(1) <<< ZERO_DEPTH_LOG;
        mx   = $signed({1'b0, qa_reg[0]});
        my   = $signed({1'b0, qa_reg[1]});
        if (sa_reg.zero) begin
            ox_next   = sa_reg.nzx ? (sa_reg.sx ? -zofs : zofs) : '0;
            oy_next   = sa_reg.nzy ? (sa_reg.sy ? -zofs : zofs) : '0;
            dimb_next = sa_reg.rpos ? QW'($signed({1'b0, DIM_MAX})) : '0;
        end else begin
            ox_next   = sa_reg.sx ? -mx : mx;
            oy_next   = sa_reg.sy ? -my : my;
            dimb_next = $signed({1'b0, qa_reg[2]});
        end
        wx_next = WW'($signed({1'b0, cx_reg})) + WW'(ox_reg);
        wy_next = WW'($signed({1'b0, cy_reg})) - WW'(oy_reg);

        sat_lo = WW'(-32'sd32768);
        sat_hi = WW'(32'sd32767);
        dmax   = WW'($signed({1'b0, DIM_MAX}));
        lim_x  = WW'($signed({1'b0, cx_reg, 1'b0}));
        lim_y  = WW'($signed({1'b0, cy_reg, 1'b0}));
        out_l  = (wx_reg + dimc_reg) < 0;
        out_r  = (wx_reg - dimc_reg) > lim_x;
        out_t  = (wy_reg + dimc_reg) < 0;
        out_b  = (wy_reg - dimc_reg) > lim_y;
        viso_next = !behc_reg && !out_l && !out_r && !out_t && !out_b;
        wxo_next  = (wx_reg < sat_lo) ? OUT_W'(sat_lo) :
                    (wx_reg > sat_hi) ? OUT_W'(sat_hi) : wx_reg[OUT_W-1:0];
        wyo_next  = (wy_reg < sat_lo) ? OUT_W'(sat_lo) :
                    (wy_reg > sat_hi) ? OUT_W'(sat_hi) : wy_reg[OUT_W-1:0];
        dimo_next = (dimc_reg > dmax) ? DIM_MAX : dimc_reg[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                qa_reg[l] <= q_div[l] + MW'(rnd_div[l]);
            end
            sa_reg   <= side_div;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            dimb_reg <= dimb_next;
            behb_reg <= sa_reg.behind;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            dimc_reg <= WW'(dimb_reg);
            behc_reg <= behb_reg;
            wxo_reg  <= wxo_next;
            wyo_reg  <= wyo_next;
            dimo_reg <= dimo_next;
            viso_reg <= viso_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            va_reg <= dv_out;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    assign m_valid         = vd_reg;
    assign m_window_x      = wxo_reg;
    assign m_window_y      = wyo_reg;
    assign m_screen_radius = dimo_reg;
    assign m_visible       = viso_reg;

    // no result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a visible disc is still not wholly left of or above the window after saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |->
            ($signed({{2{m_window_x[OUT_W-1]}}, m_window_x}) +
             $signed({2'b00, m_screen_radius})) >= 0)
        else $error("visible disc left of window");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |->
            ($signed({{2{m_window_y[OUT_W-1]}}, m_window_y}) +
             $signed({2'b00, m_screen_radius})) >= 0)
        else $error("visible disc above window");

endmodule

`default_nettype wire

// ===== design/ppc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, three lanes on one divisor
`timescale 1ns / 1ps
`default_nettype none

module ppc_div #(
    parameter int NW = 64,
    parameter int DW = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NW-1:0]       in_num [ppc_pkg::LANES],
    input  logic [DW-1:0]       in_den,
    input  ppc_pkg::div_side_t  in_side,
    output logic                out_valid,
    output logic [NW-1:0]       out_quot [ppc_pkg::LANES],
    output logic                out_round [ppc_pkg::LANES],
    output ppc_pkg::div_side_t  out_side
);
    import ppc_pkg::*;

    localparam int AW = DW + NW;

    // per stage: {remainder, numerator bits left / quotient bits so far}
    logic [AW-1:0]   acc_reg  [NW][LANES];
    logic [AW-1:0]   acc_next [NW][LANES];
    logic [DW-1:0]   den_reg  [NW];
    div_side_t       side_reg [NW];
    logic [NW-1:0]   v_reg;

    // one shift and conditional subtract per stage
    always_comb begin
        logic [AW-1:0] cur;
        logic [DW-1:0] dv;
        logic [DW:0]   t;
        logic [DW:0]   r;
        logic          qb;
        for (int k = 0; k < NW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    cur = {{DW{1'b0}}, in_num[l]};
                    dv  = in_den;
                end else begin
                    cur = acc_reg[(k == 0) ? 0 : k-1][l];
                    dv  = den_reg[(k == 0) ? 0 : k-1];
                end
                t = cur[AW-1:NW-1];
                if (t >= {1'b0, dv}) begin
                    r  = t - {1'b0, dv};
                    qb = 1'b1;
                end else begin
                    r  = t;
                    qb = 1'b0;
                end
                acc_next[k][l] = {r[DW-1:0], cur[NW-2:0], qb};
            end
        end
    end

    // stage data
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int k = 1; k < NW; k++) begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < NW; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    acc_reg[k][l] <= acc_next[k][l];
                end
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NW-2:0], in_valid};
        end
    end

    // final quotient and round-half-up decision
    logic [DW-1:0] rem_last [LANES];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rem_last[l]  = acc_reg[NW-1][l][AW-1:NW];
            out_quot[l]  = acc_reg[NW-1][l][NW-1:0];
            out_round[l] = {rem_last[l], 1'b0} >= {1'b0, den_reg[NW-1]};
        end
    end
    assign out_valid = v_reg[NW-1];
    assign out_side  = side_reg[NW-1];

    // remainder always ends below a nonzero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (den_reg[NW-1] != '0) |-> rem_last[0] < den_reg[NW-1])
        else $error("lane 0 remainder not below divisor");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (den_reg[NW-1] != '0) |-> rem_last[1] < den_reg[NW-1])
        else $error("lane 1 remainder not below divisor");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (den_reg[NW-1] != '0) |-> rem_last[2] < den_reg[NW-1])
        else $error("lane 2 remainder not below divisor");

endmodule

`default_nettype wire

// ===== verif/perspective_project_cull_top_tb.sv =====
// testbench for the perspective projection and cull block: directed table, then random spheres
`timescale 1ns / 1ps

module perspective_project_cull_top_tb;
    import ppc_pkg::*;

    localparam int CB = 21;
    localparam int AF = 14;
    localparam int LAT = CB + 56;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1130;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [3*CB-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CB-1:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic [CB-2:0] s_bound_radius = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_window_x, m_window_y;
    logic [OUT_W-1:0] m_screen_radius;
    logic m_visible;

    perspective_project_cull_top u_dut (.*);

    always #6 aclk = ~aclk;

    typedef struct packed {
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
        logic [OUT_W-1:0] rad;
        logic vis;
    } proj_t;

    typedef struct {
        logic signed [CB-1:0] px, py, pz;
        logic [CB-2:0] br;
        logic known;
        proj_t res;
    } sphere_row_t;

    // predictor's copy of the configuration
    logic [3*CB-1:0] cam_q;
    logic [47:0] view_q, right_q, up_q;
    logic [15:0] focal_q;
    logic [14:0] cx_q, cy_q;

    proj_t projections_due[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rdiv(longint num, longint den);
        longint n, q;
        n = num < 0 ? -num : num;
        q = (2 * n + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic proj_t project_sphere(logic signed [CB-1:0] px, py, pz,
                                             logic [CB-2:0] br);
        longint dv[3], rv[3], uv[3], d[3], p[3], pt[3];
        longint u, nx, ny, ox, oy, dim, wx, wy, r, rs, au, one;
        proj_t o;
        u = 0; nx = 0; ny = 0; one = 1 << AF;
        pt[0] = px; pt[1] = py; pt[2] = pz;
        for (int i = 0; i < 3; i++) begin
            dv[i] = $signed(view_q[16*i +: 16]);
            rv[i] = $signed(right_q[16*i +: 16]);
            uv[i] = $signed(up_q[16*i +: 16]);
            d[i] = pt[i] - longint'($signed(cam_q[CB*i +: CB]));
            u += d[i] * dv[i];
        end
        for (int i = 0; i < 3; i++) begin
            p[i] = d[i] * one - fl_shift(u * dv[i], AF);
            nx += p[i] * rv[i];
            ny += p[i] * uv[i];
        end
        nx = fl_shift(nx, AF) * longint'(focal_q);
        ny = fl_shift(ny, AF) * longint'(focal_q);
        r = br;
        rs = r * one;
        au = u < 0 ? -u : u;
        if (au == 0) begin
            ox = nx > 0 ? (64'sd1 <<< 40) : (nx < 0 ? -(64'sd1 <<< 40) : 0);
            oy = ny > 0 ? (64'sd1 <<< 40) : (ny < 0 ? -(64'sd1 <<< 40) : 0);
            dim = r > 0 ? 65535 : 0;
        end else begin
            ox = rdiv(nx, au);
            oy = rdiv(ny, au);
            dim = rdiv(rs * longint'(focal_q), au);
        end
        wx = longint'(cx_q) + ox;
        wy = longint'(cy_q) - oy;
        o.vis = !(u < rs || wx + dim < 0 || wx - dim > 2 * longint'(cx_q)
                  || wy + dim < 0 || wy - dim > 2 * longint'(cy_q));
        o.wx = 16'(sat(wx, -32768, 32767));
        o.wy = 16'(sat(wy, -32768, 32767));
        o.rad = 16'(sat(dim, 0, 65535));
        return o;
    endfunction

    // register write on the falling edge, applied to the predictor too
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[3*CB-1:0];
        case (idx)
            REG_CAMERA:   cam_q = val[3*CB-1:0];
            REG_VIEW:     view_q = val[47:0];
            REG_RIGHT:    right_q = val[47:0];
            REG_UP:       up_q = val[47:0];
            REG_FOCAL:    focal_q = val[15:0];
            REG_CENTER_X: cx_q = val[14:0];
            REG_CENTER_Y: cy_q = val[14:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_pipe();
        wait (projections_due.size() == 0 || timed_out);
        repeat (LAT + 10) @(negedge aclk);
    endtask

    // one sphere transfer, holding valid through the handshake
    task automatic send_sphere(logic signed [CB-1:0] px, py, pz, logic [CB-2:0] br,
                               bit chk, proj_t res, bit keep);
        proj_t e;
        s_valid <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        s_bound_radius <= br;
        e = project_sphere(px, py, pz, br);
        if (chk && e != res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: %p vs %p", res, e);
        end
        do @(posedge aclk); while (!(s_ready && !timed_out) && !timed_out);
        projections_due.push_back(chk ? res : e);
        @(negedge aclk);
        if (!keep) s_valid <= 1'b0;
    endtask

    function automatic logic signed [CB-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $signed(21'h100000);
            1: return 21'h0FFFFF;
            2: return $urandom_range(0, 4000) - 2000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rnd_axis();
        case ($urandom_range(0, 5))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h0000;
            3: return 16'h8000;
            default: return $urandom();
        endcase
    endfunction

    // receiver stall pattern
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if (phase % 600 < 150) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > WATCHDOG) timed_out = 1;
        end
        if (aresetn && m_valid && m_ready) begin
            proj_t got, want;
            got = '{m_window_x, m_window_y, m_screen_radius, m_visible};
            if (projections_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %p", got);
            end else begin
                want = projections_due.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    sphere_row_t table_rows[$];

    initial begin
        sphere_row_t row;
        proj_t none;
        int sent;
        none = '0;
        cam_q = '0;
        view_q = VIEW_RESET;
        right_q = RIGHT_RESET;
        up_q = UP_RESET;
        focal_q = FOCAL_RESET;
        cx_q = CX_RESET;
        cy_q = CY_RESET;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table; known results are from reset settings
        // on axis at depth 1024, radius 32: center, radius 400*32/1024 rounds up to 13
        table_rows.push_back('{0, 0, 1024, 32, 1, '{16'sd600, 16'sd300, 16'd13, 1'b1}});
        // zero depth, no radius: nothing offset, visible since u equals r
        table_rows.push_back('{0, 0, 0, 0, 1, '{16'sd600, 16'sd300, 16'd0, 1'b1}});
        // zero depth with radius: saturated disc, hidden
        table_rows.push_back('{0, 0, 0, 1, 1, '{16'sd600, 16'sd300, 16'hFFFF, 1'b0}});
        // zero depth with lateral offset: saturated position
        table_rows.push_back('{32, -32, 0, 0, 1, '{16'sh7FFF, 16'sh7FFF, 16'd0, 1'b0}});
        // behind the camera
        table_rows.push_back('{0, 0, -1024, 0, 0, none});
        // extremes of the fields
        table_rows.push_back('{21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 20'hFFFFF, 0, none});
        table_rows.push_back('{21'h100000, 21'h100000, 21'h100000, 20'hFFFFF, 0, none});
        table_rows.push_back('{21'h100000, 21'h0FFFFF, 21'h0FFFFF, 0, 0, none});
        table_rows.push_back('{21'h0FFFFF, 21'h100000, 21'h000001, 1, 0, none});
        // edges of the window
        table_rows.push_back('{21'sd600 * 32, 0, 21'sd12800, 0, 0, none});
        table_rows.push_back('{-21'sd600 * 32, 21'sd300 * 32, 21'sd12800, 20, 0, none});
        table_rows.push_back('{0, 0, 21'sd16, 32, 0, none});
        foreach (table_rows[i]) begin
            row = table_rows[i];
            send_sphere(row.px, row.py, row.pz, row.br, row.known, row.res,
                        i + 1 < table_rows.size());
        end
        drain_pipe();

        // random phases, each with its own settings
        sent = 0;
        for (int ph = 0; ph < 8 && !timed_out; ph++) begin
            if (ph == 0) begin
                // extremes of every register
                write_reg(REG_CAMERA, 64'h7FFF_FFFF_FFFF_FFFF);
                write_reg(REG_VIEW, 48'hFFFF_FFFF_FFFF);
                write_reg(REG_RIGHT, 48'h8000_8000_8000);
                write_reg(REG_UP, 48'h7FFF_7FFF_7FFF);
                write_reg(REG_FOCAL, 16'hFFFF);
                write_reg(REG_CENTER_X, 15'h7FFF);
                write_reg(REG_CENTER_Y, 15'h7FFF);
            end else if (ph == 1) begin
                write_reg(REG_CAMERA, 0);
                write_reg(REG_VIEW, 0);
                write_reg(REG_RIGHT, 0);
                write_reg(REG_UP, 0);
                write_reg(REG_FOCAL, 1);
                write_reg(REG_CENTER_X, 0);
                write_reg(REG_CENTER_Y, 0);
            end else if (ph == 2) begin
                write_reg(REG_CAMERA, 0);
                write_reg(REG_VIEW, VIEW_RESET);
                write_reg(REG_RIGHT, RIGHT_RESET);
                write_reg(REG_UP, UP_RESET);
                write_reg(REG_FOCAL, FOCAL_RESET);
                write_reg(REG_CENTER_X, CX_RESET);
                write_reg(REG_CENTER_Y, CY_RESET);
            end else begin
                write_reg(REG_CAMERA, {$urandom(), $urandom()});
                write_reg(REG_VIEW, {rnd_axis(), rnd_axis(), rnd_axis()});
                write_reg(REG_RIGHT, {rnd_axis(), rnd_axis(), rnd_axis()});
                write_reg(REG_UP, {rnd_axis(), rnd_axis(), rnd_axis()});
                write_reg(REG_FOCAL, $urandom_range(1, 65535));
                write_reg(REG_CENTER_X, $urandom());
                write_reg(REG_CENTER_Y, $urandom());
            end
            for (int b = 0; b < 1000 && sent < N_RANDOM * (ph + 1) / 8
                 && !timed_out; b++) begin
                int burst;
                burst = $urandom_range(1, 30);
                for (int k = 0; k < burst && sent < N_RANDOM * (ph + 1) / 8; k++) begin
                    send_sphere(rnd_coord(), rnd_coord(), rnd_coord(),
                                $urandom_range(0, 3) == 0 ? 20'($urandom())
                                                          : 20'($urandom_range(0, 200)),
                                0, none,
                                k + 1 < burst && sent + 1 < N_RANDOM * (ph + 1) / 8);
                    sent++;
                end
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            // pause until every result is back, then reconfigure
            drain_pipe();
        end

        drain_pipe();
        if (!timed_out && mismatches == 0 && projections_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // timeout ends the run
    initial begin
        wait (timed_out);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/ppc_pkg.sv
design/ppc_div.sv
design/perspective_project_cull_top.sv
verif/perspective_project_cull_top_tb.sv
